// ===== src/scba_pkg.sv =====
// Package for the size-class block allocator: constants, payload structs,
// controller/datapath command and status types. No dependencies.
`default_nettype none
package scba_pkg;
  localparam int unsigned SizeClasses = 2048;
  localparam int unsigned ChunkBytes = 32768;
  localparam int unsigned GranuleBytes = 16;
  localparam int unsigned HeaderBytes = 8;
  localparam int unsigned HeapGranules = 65536;
  localparam int unsigned ChunkGranules = ChunkBytes / GranuleBytes;
  localparam int unsigned ClsW = $clog2(SizeClasses);
  localparam int unsigned AddrW = $clog2(HeapGranules);
  localparam int unsigned PtrW = AddrW + 1;
  localparam int unsigned RemW = $clog2(ChunkGranules) + 1;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNoMem = 2'd1;
  localparam logic [1:0] StTooLarge = 2'd2;
  localparam logic [1:0] StBadFree = 2'd3;
  localparam logic OpAlloc = 1'b0;

  typedef struct packed {
    logic        opcode;
    logic [15:0] request_bytes;
    logic [15:0] block_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] address;
    logic [10:0] block_granules;
    logic [16:0] in_use_granules;
    logic [16:0] heap_granules;
    logic [31:0] alloc_count;
    logic [31:0] free_count;
    logic [31:0] fail_count;
    logic [31:0] invalid_count;
    logic [5:0]  chunk_count;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;   // capture request, issue head read
    logic fetch;   // header read
    logic decide;  // use read data, update memories and counters
    logic finish;  // list push write-back, drive result
  } cmd_t;

  typedef struct packed {
    logic done;
  } sts_t;
endpackage
`default_nettype wire

// ===== src/scba_ctrl.sv =====
// Controller FSM of the allocator: sequences a transaction through read,
// decide and write-back steps. Depends on scba_pkg.
`default_nettype none
module scba_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  output scba_pkg::cmd_t     cmd_o
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_READ = 4'b0010, S_DECIDE = 4'b0100, S_DONE = 4'b1000
  } state_e;
  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (start_i) state_d = S_READ;
      S_READ:   state_d = S_DECIDE;
      S_DECIDE: state_d = S_DONE;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign cmd_o.latch = (state_q == S_IDLE) && start_i;
  assign cmd_o.fetch = (state_q == S_READ);
  assign cmd_o.decide = (state_q == S_DECIDE);
  assign cmd_o.finish = (state_q == S_DONE);
endmodule
`default_nettype wire

// ===== src/scba_dp.sv =====
// Datapath of the allocator: class head memory with clearing pass, header
// memory, bump region, counters and result register. Depends on scba_pkg.
`default_nettype none
module scba_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire scba_pkg::cmd_t cmd_i,
  input  wire scba_pkg::req_t req_i,
  input  wire logic           cfg_we_i,
  input  wire logic [5:0]     cfg_wdata_i,
  output logic                clearing_o,
  output logic                result_valid_o,
  output scba_pkg::rsp_t      result_o
);
  localparam int unsigned CW = scba_pkg::ClsW;
  localparam int unsigned AW = scba_pkg::AddrW;
  localparam int unsigned PW = scba_pkg::PtrW;
  localparam int unsigned RW = scba_pkg::RemW;
  localparam logic [PW-1:0] Nil = PW'(scba_pkg::HeapGranules);
  localparam int unsigned MaxChunks = scba_pkg::HeapGranules / scba_pkg::ChunkGranules;

  logic [PW-1:0] heads_mem [scba_pkg::SizeClasses];
  logic [17:0]   hdr_mem [scba_pkg::HeapGranules];

  logic [5:0]    limit_q;
  logic [CW:0]   clr_q;
  logic          op_q, big_q;
  logic [CW-1:0] cls_q;
  logic [AW-1:0] faddr_q;
  logic [PW-1:0] head_rd_q;
  logic [17:0]   hdr_rd_q;
  logic [PW-1:0] bump_addr_q;
  logic [RW-1:0] bump_rem_q;
  logic [5:0]    chunks_q;
  logic [16:0]   in_use_q;
  logic [31:0]   cnt_alloc_q, cnt_free_q, cnt_fail_q, cnt_inv_q;
  logic [1:0]    st_q;
  logic [15:0]   raddr_q;
  logic [10:0]   rcls_q;
  logic          result_valid_q;
  logic          push_q;
  logic [CW-1:0] pcls_q;
  logic [AW-1:0] paddr_q;

  logic [16:0] cls_full;
  assign cls_full = (17'(req_i.request_bytes) + 17'(scba_pkg::HeaderBytes)
                     + 17'(scba_pkg::GranuleBytes - 1)) >> $clog2(scba_pkg::GranuleBytes);

  assign clearing_o = !clr_q[CW];
  assign result_valid_o = result_valid_q;

  // decide
  logic          pop, carve, need_chunk, chunk_ok, bad_free, push_d;
  logic [PW-1:0] base;
  logic [CW-1:0] pcls_d;
  logic [AW-1:0] paddr_d;
  logic [1:0]    st_d;
  logic [15:0]   raddr_d;
  logic [10:0]   rcls_d;
  always_comb begin
    base = PW'(chunks_q) << $clog2(scba_pkg::ChunkGranules);
    pop = !op_q && !big_q && !head_rd_q[AW];
    need_chunk = !op_q && !big_q && head_rd_q[AW] && (RW'(cls_q) > bump_rem_q);
    chunk_ok = (chunks_q < limit_q) && (7'(chunks_q) < 7'(MaxChunks));
    carve = !op_q && !big_q && head_rd_q[AW] && (!need_chunk || chunk_ok);
    bad_free = op_q && (!hdr_rd_q[17] || (hdr_rd_q[16:0] >= 17'(scba_pkg::SizeClasses)));
    // a valid free pushes the block; needing a new chunk pushes the region leftover, even if refused
    pcls_d = op_q ? hdr_rd_q[CW-1:0] : bump_rem_q[CW-1:0];
    paddr_d = op_q ? faddr_q : bump_addr_q[AW-1:0];
    push_d = op_q ? !bad_free : (need_chunk && (bump_rem_q != '0));
    st_d = scba_pkg::StNoMem; raddr_d = '0; rcls_d = '0;
    if (op_q) begin
      st_d = bad_free ? scba_pkg::StBadFree : scba_pkg::StOk;
      if (!bad_free) rcls_d = hdr_rd_q[10:0];
    end else if (big_q) st_d = scba_pkg::StTooLarge;
    else if (pop) begin
      st_d = scba_pkg::StOk; raddr_d = head_rd_q[15:0]; rcls_d = 11'(cls_q);
    end else if (carve) begin
      st_d = scba_pkg::StOk; rcls_d = 11'(cls_q);
      raddr_d = need_chunk ? base[15:0] : bump_addr_q[15:0];
    end
  end

  // memory ports
  logic          hw_en;
  logic [CW-1:0] hw_idx;
  logic [PW-1:0] hw_dat;
  logic          xw_en;
  logic [AW-1:0] xw_idx;
  logic [17:0]   xw_dat;
  logic [CW-1:0] head_raddr;
  logic [AW-1:0] hdr_raddr;

  assign head_raddr = cmd_i.latch ? cls_full[CW-1:0] : pcls_d;
  assign hdr_raddr = op_q ? faddr_q : head_rd_q[AW-1:0];

  always_comb begin
    hw_en = 1'b0; hw_idx = cls_q; hw_dat = Nil;
    xw_en = 1'b0; xw_idx = paddr_q; xw_dat = {1'b0, head_rd_q};
    if (clearing_o) begin
      hw_en = 1'b1; hw_idx = clr_q[CW-1:0];
    end else if (cmd_i.decide) begin
      if (pop) begin
        hw_en = 1'b1; hw_dat = hdr_rd_q[PW-1:0];
        xw_en = 1'b1; xw_idx = head_rd_q[AW-1:0]; xw_dat = {1'b1, 6'd0, cls_q};
      end else if (carve) begin
        xw_en = 1'b1; xw_dat = {1'b1, 6'd0, cls_q};
        xw_idx = need_chunk ? base[AW-1:0] : bump_addr_q[AW-1:0];
      end
    end else if (cmd_i.finish && push_q) begin
      hw_en = 1'b1; hw_idx = pcls_q; hw_dat = {1'b0, paddr_q};
      xw_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hw_en) heads_mem[hw_idx] <= hw_dat;
    if (cmd_i.latch || cmd_i.decide) head_rd_q <= heads_mem[head_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (xw_en) hdr_mem[xw_idx] <= xw_dat;
    if (cmd_i.fetch) hdr_rd_q <= hdr_mem[hdr_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 6'd32; clr_q <= '0;
      bump_addr_q <= '0; bump_rem_q <= '0; chunks_q <= '0; in_use_q <= '0;
      cnt_alloc_q <= '0; cnt_free_q <= '0; cnt_fail_q <= '0; cnt_inv_q <= '0;
      result_valid_q <= 1'b0; push_q <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (clearing_o) clr_q <= clr_q + 1'b1;
      result_valid_q <= cmd_i.finish;
      if (cmd_i.decide) begin
        push_q <= push_d;
        if (op_q) begin
          if (bad_free) cnt_inv_q <= cnt_inv_q + 1'b1;
          else begin
            cnt_free_q <= cnt_free_q + 1'b1;
            in_use_q <= in_use_q - 17'(hdr_rd_q[CW-1:0]);
          end
        end else if (!big_q) begin
          if (need_chunk) begin
            if (!chunk_ok) begin
              cnt_fail_q <= cnt_fail_q + 1'b1;
              bump_rem_q <= '0;
            end else begin
              chunks_q <= chunks_q + 1'b1;
              bump_addr_q <= base + PW'(cls_q);
              bump_rem_q <= RW'(scba_pkg::ChunkGranules) - RW'(cls_q);
            end
          end else if (!pop) begin
            bump_addr_q <= bump_addr_q + PW'(cls_q);
            bump_rem_q <= bump_rem_q - RW'(cls_q);
          end
          if (pop || carve) begin
            cnt_alloc_q <= cnt_alloc_q + 1'b1;
            in_use_q <= in_use_q + 17'(cls_q);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q <= req_i.opcode;
      big_q <= (req_i.opcode == scba_pkg::OpAlloc) && (cls_full >= 17'(scba_pkg::SizeClasses));
      cls_q <= cls_full[CW-1:0];
      faddr_q <= req_i.block_address[AW-1:0];
    end
    if (cmd_i.decide) begin
      pcls_q <= pcls_d; paddr_q <= paddr_d;
      st_q <= st_d; raddr_q <= raddr_d; rcls_q <= rcls_d;
    end
  end

  always_comb begin
    result_o.status = st_q;
    result_o.address = raddr_q;
    result_o.block_granules = rcls_q;
    result_o.in_use_granules = in_use_q;
    result_o.heap_granules = 17'(chunks_q) << $clog2(scba_pkg::ChunkGranules);
    result_o.alloc_count = cnt_alloc_q;
    result_o.free_count = cnt_free_q;
    result_o.fail_count = cnt_fail_q;
    result_o.invalid_count = cnt_inv_q;
    result_o.chunk_count = chunks_q;
  end
endmodule
`default_nettype wire

// ===== src/size_class_block_allocator_top.sv =====
// Top level of the size-class block allocator: controller plus datapath.
// Depends on scba_pkg, scba_ctrl and scba_dp.
// A transaction is accepted at a rising edge with start high and busy low.
// busy then stays high through the header read, decide and write-back states
// (the head read is issued at acceptance), and result_valid_o, registered from
// the write-back state, rises with the result on result_o once busy has fallen;
// a new transaction is accepted only while busy is low. After reset a clearing
// pass writes Nil to each of the 2048 class heads, emptying the class lists;
// busy is high meanwhile. The receiver cannot stall: result_valid_o is high for one cycle per result.
`default_nettype none
module size_class_block_allocator_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire scba_pkg::req_t req_i,
  input  wire logic           cfg_we_i,
  input  wire logic [5:0]     cfg_wdata_i,
  output logic                result_valid_o,
  output scba_pkg::rsp_t      result_o
);
  scba_pkg::cmd_t cmd;
  logic ctrl_busy, clearing;

  scba_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start && !clearing), .busy_o(ctrl_busy), .cmd_o(cmd)
  );
  scba_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .req_i, .cfg_we_i, .cfg_wdata_i,
    .clearing_o(clearing), .result_valid_o, .result_o
  );
  assign busy = ctrl_busy || clearing;

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("double strobe");
  a_busy_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("start not taken");
  a_result_ok_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status != scba_pkg::StOk) |-> result_o.address == '0)
    else $error("address on failure");
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for size_class_block_allocator_top: predicts each result
// from a behavioral model of the size-class lists and bump region.
// Depends on scba_pkg and the allocator RTL.
`default_nettype none
module tb_top;
  localparam logic OpFree = 1'b1;
  localparam logic [16:0] NilPtr = 17'h10000;
  localparam logic [17:0] AllocTag = 18'h20000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  scba_pkg::req_t       req_i = '0;
  logic                 cfg_we_i = 1'b0;
  logic [5:0]           cfg_wdata_i = '0;
  logic                 result_valid_o;
  scba_pkg::rsp_t       result_o;

  size_class_block_allocator_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i), .result_valid_o(result_valid_o),
    .result_o(result_o)
  );

  always #10 clk_i = ~clk_i;

  // allocator shadow state
  logic [16:0] list_head [scba_pkg::SizeClasses];
  logic [17:0] hdr_word [scba_pkg::HeapGranules];
  bit          hdr_written [scba_pkg::HeapGranules];
  int unsigned bump_at, bump_left, chunks_used, chunk_cap;
  logic [16:0] granules_out;
  logic [31:0] n_alloc, n_free, n_fail, n_invalid;

  scba_pkg::rsp_t expected_rsp_q[$];
  int   live_blocks[$];
  int   written_blocks[$];
  int   mismatches = 0;
  bit   idle_en = 1'b1;

  function automatic void mark_header(int unsigned a, logic [17:0] w);
    hdr_word[a] = w;
    if (!hdr_written[a]) begin
      hdr_written[a] = 1'b1;
      written_blocks.push_back(a);
    end
  endfunction

  function automatic void push_free(int unsigned c, int unsigned a);
    if (c < scba_pkg::SizeClasses && a < scba_pkg::HeapGranules) begin
      mark_header(a, {1'b0, list_head[c]});
      list_head[c] = a[16:0];
    end
  endfunction

  function automatic scba_pkg::rsp_t heap_snapshot(logic [1:0] st, int unsigned a,
                                                   int unsigned c);
    scba_pkg::rsp_t r;
    r.status = st;
    r.address = a[15:0];
    r.block_granules = c[10:0];
    r.in_use_granules = granules_out;
    r.heap_granules = 17'(chunks_used * scba_pkg::ChunkGranules);
    r.alloc_count = n_alloc;
    r.free_count = n_free;
    r.fail_count = n_fail;
    r.invalid_count = n_invalid;
    r.chunk_count = chunks_used[5:0];
    return r;
  endfunction

  function automatic scba_pkg::rsp_t predict_alloc_free(scba_pkg::req_t rq);
    int unsigned c, a, base;
    logic [17:0] h;
    if (rq.opcode == scba_pkg::OpAlloc) begin
      c = (32'(rq.request_bytes) + scba_pkg::HeaderBytes + scba_pkg::GranuleBytes - 1)
          / scba_pkg::GranuleBytes;
      if (c >= scba_pkg::SizeClasses) return heap_snapshot(scba_pkg::StTooLarge, 0, 0);
      if (list_head[c] < scba_pkg::HeapGranules) begin
        a = 32'(list_head[c]);
        list_head[c] = hdr_word[a][16:0];
      end else begin
        if (c > bump_left) begin
          base = chunks_used * scba_pkg::ChunkGranules;
          if (bump_left != 0) push_free(bump_left, bump_at);
          bump_left = 0;
          if (chunks_used >= chunk_cap ||
              base + scba_pkg::ChunkGranules > scba_pkg::HeapGranules) begin
            n_fail++;
            return heap_snapshot(scba_pkg::StNoMem, 0, 0);
          end
          chunks_used++;
          bump_at = base;
          bump_left = scba_pkg::ChunkGranules;
        end
        a = bump_at;
        bump_at += c;
        bump_left -= c;
      end
      mark_header(a, AllocTag | 18'(c));
      n_alloc++;
      granules_out = granules_out + 17'(c);
      return heap_snapshot(scba_pkg::StOk, a, c);
    end
    a = 32'(rq.block_address);
    h = hdr_word[a];
    if (!h[17] || h[16:0] >= scba_pkg::SizeClasses) begin
      n_invalid++;
      return heap_snapshot(scba_pkg::StBadFree, 0, 0);
    end
    c = 32'(h[16:0]);
    n_free++;
    granules_out = granules_out - 17'(c);
    push_free(c, a);
    return heap_snapshot(scba_pkg::StOk, 0, c);
  endfunction

  task automatic send_request(logic op, logic [15:0] nbytes, logic [15:0] blk);
    scba_pkg::req_t rq;
    scba_pkg::rsp_t r;
    start = 1'b0;
    if (idle_en) while ($urandom_range(99) < 37) @(negedge clk_i);
    rq.opcode = op;
    rq.request_bytes = nbytes;
    rq.block_address = blk;
    req_i = rq;
    start = 1'b1;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    r = predict_alloc_free(rq);
    expected_rsp_q.push_back(r);
    if (r.status == scba_pkg::StOk) begin
      if (op == scba_pkg::OpAlloc) live_blocks.push_back(int'(r.address));
      else foreach (live_blocks[i]) if (live_blocks[i] == blk) begin
        live_blocks.delete(i);
        break;
      end
    end
    @(negedge clk_i);
    start = 1'b0;
    req_i = scba_pkg::req_t'({1'($urandom), 16'($urandom), 16'($urandom)});
  endtask

  task automatic alloc_bytes(int unsigned n);
    send_request(scba_pkg::OpAlloc, n[15:0], 16'($urandom));
  endtask

  task automatic free_live();
    int unsigned k;
    if (live_blocks.size() == 0) begin
      alloc_bytes($urandom_range(0, 200));
      return;
    end
    k = $urandom_range(live_blocks.size() - 1);
    send_request(OpFree, 16'($urandom), live_blocks[k][15:0]);
  endtask

  task automatic free_stale();
    int unsigned k;
    if (written_blocks.size() == 0) return;
    k = $urandom_range(written_blocks.size() - 1);
    send_request(OpFree, 16'($urandom), written_blocks[k][15:0]);
  endtask

  task automatic set_chunk_limit(logic [5:0] v);
    while (expected_rsp_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    chunk_cap = 32'(v);
  endtask

  always @(posedge clk_i) begin
    scba_pkg::rsp_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", result_o);
      end else begin
        e = expected_rsp_q.pop_front();
        if (result_o !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("exp %p\ngot %p", e, result_o);
        end
      end
    end
  end

  task automatic test_no_chunks();
    set_chunk_limit(6'd0);
    alloc_bytes(0);
    alloc_bytes(65535);
    alloc_bytes(32760);
  endtask

  task automatic test_directed();
    int unsigned a0;
    set_chunk_limit(6'd1);
    alloc_bytes(0);
    alloc_bytes(8);
    alloc_bytes(9);
    alloc_bytes(32744);
    a0 = live_blocks[0];
    send_request(OpFree, 16'hffff, a0[15:0]);
    send_request(OpFree, 16'h0000, a0[15:0]);
    alloc_bytes(1);
    alloc_bytes(32744);
    alloc_bytes(32744);
    alloc_bytes(65535);
    free_live();
    free_live();
    free_stale();
    alloc_bytes(200);
  endtask

  task automatic test_random(int unsigned count, logic [5:0] lim);
    int unsigned p;
    set_chunk_limit(lim);
    repeat (count) begin
      p = $urandom_range(99);
      if (p < 40) alloc_bytes($urandom_range(0, 255));
      else if (p < 48) alloc_bytes($urandom_range(256, 32743));
      else if (p < 52) alloc_bytes($urandom);
      else if (p < 88) free_live();
      else free_stale();
    end
  endtask

  initial begin
    foreach (list_head[i]) list_head[i] = NilPtr;
    bump_at = 0; bump_left = 0; chunks_used = 0; chunk_cap = 32;
    granules_out = '0;
    n_alloc = '0; n_free = '0; n_fail = '0; n_invalid = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_no_chunks();
    test_directed();
    idle_en = 1'b0;
    test_random(300, 6'd3);
    idle_en = 1'b1;
    test_random(600, 6'd32);
    test_random(400, 6'd63);
    test_random(300, 6'd2);
    test_random(330, 6'd32);
    while (expected_rsp_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) $display("size_class_block_allocator_top: match");
    else $display("size_class_block_allocator_top: mismatch");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("size_class_block_allocator_top: mismatch");
    $finish;
  end
endmodule
`default_nettype wire

// ===== size_class_block_allocator_top.f =====
src/scba_pkg.sv
src/scba_ctrl.sv
src/scba_dp.sv
src/size_class_block_allocator_top.sv
bench/tb_top.sv
